// ===== hdl/csl_pkg.sv =====
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants for the command slew limiter
// Holds the register indexes, sequencer states, the request and status
// bundles of the shared arithmetic unit, and fixed field widths.
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam int DT_WIDTH      = 17;
    localparam int TURN_WIDTH    = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int Q30_FRAC      = 30;

    localparam logic [DT_WIDTH-1:0] DT_RESET = 17'd655;

    // pi and 2*pi with 30 fraction bits, rounded to nearest at the live format later
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam logic signed [TURN_WIDTH-1:0] TURN_STEP = 16'sd2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_MODE        = 3'd0,
        CFG_STEP_TIME   = 3'd1,
        CFG_VALUE_UPPER = 3'd2,
        CFG_VALUE_LOWER = 3'd3,
        CFG_RATE_UPPER  = 3'd4,
        CFG_RATE_LOWER  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SUM,
        S_WRAP,
        S_BOUND,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // Round a Q30 constant to nearest at the given fraction width
    function automatic logic [63:0] q_round(input logic [63:0] c30, input int frac);
        logic [63:0] t;
        t = (c30 << 1) >> (Q30_FRAC - frac);
        return (t + 64'd1) >> 1;
    endfunction

endpackage

// ===== hdl/csl_in_if.sv =====
// ----------------------------------------------------------------------------
// csl_in_if: command input channel
// Valid/ready channel carrying the operation select and the sample word.
// ----------------------------------------------------------------------------
interface csl_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [DATA_WIDTH-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

// ===== hdl/csl_out_if.sv =====
// ----------------------------------------------------------------------------
// csl_out_if: shaped command output channel
// Valid/ready channel carrying the new value, rate and turn count.
// ----------------------------------------------------------------------------
interface csl_out_if import csl_pkg::*; #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value_out;
    logic signed [DATA_WIDTH-1:0] rate_out;
    logic signed [TURN_WIDTH-1:0] turns_out;

    modport source (output valid, output value_out, output rate_out, output turns_out,
                    input ready);
    modport sink   (input valid, input value_out, input rate_out, input turns_out,
                    output ready);
endinterface

// ===== hdl/csl_muldiv.sv =====
// ----------------------------------------------------------------------------
// csl_muldiv: shared multiply / divide unit
// Multiplies a signed word by dt into a product register, or divides a signed
// numerator by dt one quotient bit per cycle (restoring, truncating).
// ----------------------------------------------------------------------------
module csl_muldiv import csl_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_unit_req                                     i_req,
    output t_unit_stat                                    o_stat,
    input  logic signed [DATA_WIDTH-1:0]                  i_mul_a,
    input  logic        [DT_WIDTH-1:0]                    i_dt,
    input  logic signed [DATA_WIDTH+FRAC_BITS:0]          i_num,
    output logic signed [DATA_WIDTH+DT_WIDTH:0]           o_prod,
    output logic signed [DATA_WIDTH+FRAC_BITS:0]          o_quot
);
    localparam int NUM_W  = DATA_WIDTH + FRAC_BITS + 1;
    localparam int PROD_W = DATA_WIDTH + DT_WIDTH + 1;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    logic signed [PROD_W-1:0] r_prod;
    logic        [NUM_W-1:0]  r_quo;
    logic        [DT_WIDTH-1:0] r_rem;
    logic        [DT_WIDTH-1:0] r_dvs;
    logic                     r_neg;
    logic        [CNT_W-1:0]  r_cnt;
    logic                     r_done;

    logic        [NUM_W-1:0]  w_mag;
    logic        [DT_WIDTH:0] w_trial;
    logic        [DT_WIDTH:0] w_sub;
    logic                     w_fits;

    assign w_mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_dvs};
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && i_req.is_div) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !i_req.is_div) begin
            r_prod <= i_mul_a * $signed({1'b0, i_dt});
        end
        if (i_req.start && i_req.is_div) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_dvs <= i_dt;
            r_neg <= i_num[NUM_W-1];
        end else if (r_cnt != '0) begin
            // shift in one numerator bit, subtract where the divisor fits
            r_rem <= w_fits ? w_sub[DT_WIDTH-1:0] : w_trial[DT_WIDTH-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
    end

    assign o_prod      = r_prod;
    assign o_quot      = r_neg ? $signed(-r_quo) : $signed(r_quo);
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_cnt == '0))
        else $error("unit started while a division is running");

    a_div_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && i_req.is_div) |=> (r_cnt == CNT_W'(NUM_W)))
        else $error("division did not load its bit count");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0) && $past(r_cnt == CNT_W'(1)))
        else $error("division done out of step with its counter");

endmodule

// ===== hdl/command_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// command_slew_limiter: rate and range shaping of one command channel
// Signed fixed point command shaper with position, velocity and wrapped
// angle operation, built around one shared multiply / divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per command: op (0 limited, 1 wrapped angle) and
//   the sample. o_out returns one word per command: new value, new rate and
//   the turn count. The configuration port writes one register per cycle
//   with i_cfg_we; write it only while no command is in flight.
// Sequencing:
//   i_in.ready is high only while the sequencer is idle, so one command is
//   worked at a time. Out-of-range position targets go from S_LOAD to S_OUT,
//   wrapped angles through S_MUL, S_SUM and S_WRAP, velocity commands through
//   S_MUL, S_SUM and S_BOUND, and limited position steps through S_MUL and
//   S_SUM twice, then S_CMP; a position step inside the rate limits then waits
//   in S_DIV on the bit-serial divider for its Q16.16 rate (default widths).
//   Ready returns in the cycle after a word is committed.
// Reset:
//   Synchronous, active low. Value, rate and turn count go to zero, mode to
//   position, dt to 655 and all bounds wide open.
// Stall:
//   A finished word sits in the output register until taken; a new command
//   is accepted meanwhile, but its result is held back until the first word
//   has left.
// ----------------------------------------------------------------------------
module command_slew_limiter import csl_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [((DATA_WIDTH > DT_WIDTH) ? DATA_WIDTH : DT_WIDTH)-1:0] i_cfg_data,
    csl_in_if.sink                   i_in,
    csl_out_if.source                o_out
);
    localparam int NUM_W  = DATA_WIDTH + FRAC_BITS + 1;
    localparam int PROD_W = DATA_WIDTH + DT_WIDTH + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DIFF_W = DATA_WIDTH + 1;

    localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]      SUM_MAX = SUM_W'(D_MAX);
    localparam logic signed [SUM_W-1:0]      SUM_MIN = SUM_W'(D_MIN);
    localparam logic signed [NUM_W-1:0]      QUO_MAX = NUM_W'(D_MAX);
    localparam logic signed [NUM_W-1:0]      QUO_MIN = NUM_W'(D_MIN);

    localparam logic signed [DATA_WIDTH-1:0] PI_D =
        DATA_WIDTH'(q_round(PI_Q30, FRAC_BITS));
    localparam logic signed [DATA_WIDTH-1:0] TWO_PI_D =
        DATA_WIDTH'(q_round(TWO_PI_Q30, FRAC_BITS));
    localparam logic signed [DATA_WIDTH-1:0] NEG_PI_D = -PI_D;

    // saturate a grown sum back to the data range
    function automatic logic signed [DATA_WIDTH-1:0] sat_sum(
        input logic signed [SUM_W-1:0] x);
        if (x > SUM_MAX) begin
            return D_MAX;
        end else if (x < SUM_MIN) begin
            return D_MIN;
        end
        return x[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_quo(
        input logic signed [NUM_W-1:0] x);
        if (x > QUO_MAX) begin
            return D_MAX;
        end else if (x < QUO_MIN) begin
            return D_MIN;
        end
        return x[DATA_WIDTH-1:0];
    endfunction

    // configuration
    logic                         r_mode;
    logic [DT_WIDTH-1:0]          r_step_time;
    logic signed [DATA_WIDTH-1:0] r_value_upper, r_value_lower;
    logic signed [DATA_WIDTH-1:0] r_rate_upper, r_rate_lower;

    // sequencer and channel state
    t_state                       r_state, n_state;
    logic                         r_out_valid, n_out_valid;
    logic signed [DATA_WIDTH-1:0] r_value, n_value;
    logic signed [DATA_WIDTH-1:0] r_rate, n_rate;
    logic signed [TURN_WIDTH-1:0] r_turns, n_turns;

    // per-command working registers
    logic                         r_op, n_op;
    logic signed [DATA_WIDTH-1:0] r_sample, n_sample;
    logic signed [DATA_WIDTH-1:0] r_arg, n_arg;
    logic                         r_pass, n_pass;
    logic signed [DATA_WIDTH-1:0] r_top, n_top;
    logic signed [DATA_WIDTH-1:0] r_sum, n_sum;
    logic signed [DATA_WIDTH-1:0] r_new_value, n_new_value;
    logic signed [DATA_WIDTH-1:0] r_new_rate, n_new_rate;
    logic signed [TURN_WIDTH-1:0] r_new_turns, n_new_turns;

    // shared unit
    t_unit_req                    w_req;
    t_unit_stat                   w_stat;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [PROD_W-1:0]     w_prod_sh;
    logic signed [NUM_W-1:0]      w_quot;
    logic signed [NUM_W-1:0]      w_num;
    logic signed [DIFF_W-1:0]     w_diff;
    logic signed [DATA_WIDTH-1:0] w_sum_sat;
    logic                         w_commit;

    csl_muldiv #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_stat),
        .i_mul_a (r_arg),
        .i_dt    (r_step_time),
        .i_num   (w_num),
        .o_prod  (w_prod),
        .o_quot  (w_quot)
    );

    // rate*dt floors through the arithmetic shift
    assign w_prod_sh = w_prod >>> FRAC_BITS;
    assign w_sum_sat = sat_sum(SUM_W'(r_value) + SUM_W'(w_prod_sh));
    // exact numerator of (target - value) / dt
    assign w_diff    = DIFF_W'(r_sample) - DIFF_W'(r_value);
    assign w_num     = $signed({w_diff, {FRAC_BITS{1'b0}}});
    assign w_commit  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_op && !r_mode &&
                    (r_sample > r_value_upper || r_sample < r_value_lower)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_SUM;
            S_SUM: begin
                if (r_op) begin
                    n_state = S_WRAP;
                end else if (r_mode) begin
                    n_state = S_BOUND;
                end else if (!r_pass) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_WRAP:  n_state = S_OUT;
            S_BOUND: n_state = S_OUT;
            S_CMP: begin
                if (r_sample > r_top || r_sample < r_sum || r_step_time == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_stat.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and unit requests
    // ------------------------------------------------------------------
    always_comb begin
        w_req       = '0;
        n_op        = r_op;
        n_sample    = r_sample;
        n_arg       = r_arg;
        n_pass      = r_pass;
        n_top       = r_top;
        n_sum       = r_sum;
        n_new_value = r_new_value;
        n_new_rate  = r_new_rate;
        n_new_turns = r_new_turns;
        n_value     = r_value;
        n_rate      = r_rate;
        n_turns     = r_turns;
        n_out_valid = r_out_valid;

        // drop the output word once taken
        if (r_out_valid && o_out.ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op     = i_in.op;
                    n_sample = i_in.sample;
                end
            end
            S_LOAD: begin
                n_new_turns = r_turns;
                n_pass      = 1'b0;
                if (r_op) begin
                    n_arg = r_sample;
                end else if (!r_mode) begin
                    // a target beyond the value bounds parks at the bound
                    if (r_sample > r_value_upper) begin
                        n_new_value = r_value_upper;
                        n_new_rate  = '0;
                    end else if (r_sample < r_value_lower) begin
                        n_new_value = r_value_lower;
                        n_new_rate  = '0;
                    end else begin
                        n_arg = r_rate_upper;
                    end
                end else begin
                    // clamp the commanded velocity
                    if (r_sample > r_rate_upper) begin
                        n_arg = r_rate_upper;
                    end else if (r_sample < r_rate_lower) begin
                        n_arg = r_rate_lower;
                    end else begin
                        n_arg = r_sample;
                    end
                end
            end
            S_MUL: begin
                w_req.start  = 1'b1;
                w_req.is_div = 1'b0;
            end
            S_SUM: begin
                n_sum = w_sum_sat;
                if (!r_op && !r_mode && !r_pass) begin
                    // first pass gave the upper step; run again for the lower
                    n_top  = w_sum_sat;
                    n_arg  = r_rate_lower;
                    n_pass = 1'b1;
                end
            end
            S_WRAP: begin
                n_new_rate = r_sample;
                if (r_sum > PI_D) begin
                    n_new_value = sat_sum(SUM_W'(r_sum) - SUM_W'(TWO_PI_D));
                    n_new_turns = r_turns + TURN_STEP;
                end else if (r_sum < NEG_PI_D) begin
                    n_new_value = sat_sum(SUM_W'(r_sum) + SUM_W'(TWO_PI_D));
                    n_new_turns = r_turns - TURN_STEP;
                end else begin
                    n_new_value = r_sum;
                end
            end
            S_BOUND: begin
                if (r_sum > r_value_upper) begin
                    n_new_value = r_value_upper;
                    n_new_rate  = '0;
                end else if (r_sum < r_value_lower) begin
                    n_new_value = r_value_lower;
                    n_new_rate  = '0;
                end else begin
                    n_new_value = r_sum;
                    n_new_rate  = r_arg;
                end
            end
            S_CMP: begin
                // r_top holds the upper reach, r_sum the lower reach
                if (r_sample > r_top) begin
                    n_new_value = r_top;
                    n_new_rate  = r_rate_upper;
                end else if (r_sample < r_sum) begin
                    n_new_value = r_sum;
                    n_new_rate  = r_rate_lower;
                end else if (r_step_time == '0) begin
                    n_new_value = r_sample;
                    n_new_rate  = '0;
                end else begin
                    w_req.start  = 1'b1;
                    w_req.is_div = 1'b1;
                end
            end
            S_DIV: begin
                if (w_stat.done) begin
                    n_new_value = r_sample;
                    n_new_rate  = sat_quo(w_quot);
                end
            end
            S_OUT: begin
                // commit the channel state; it doubles as the output word
                if (w_commit) begin
                    n_value     = r_new_value;
                    n_rate      = r_new_rate;
                    n_turns     = r_new_turns;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_value     <= '0;
            r_rate      <= '0;
            r_turns     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_value     <= n_value;
            r_rate      <= n_rate;
            r_turns     <= n_turns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_step_time   <= DT_RESET;
            r_value_upper <= D_MAX;
            r_value_lower <= D_MIN;
            r_rate_upper  <= D_MAX;
            r_rate_lower  <= D_MIN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:        r_mode        <= i_cfg_data[0];
                CFG_STEP_TIME:   r_step_time   <= i_cfg_data[DT_WIDTH-1:0];
                CFG_VALUE_UPPER: r_value_upper <= $signed(i_cfg_data[DATA_WIDTH-1:0]);
                CFG_VALUE_LOWER: r_value_lower <= $signed(i_cfg_data[DATA_WIDTH-1:0]);
                CFG_RATE_UPPER:  r_rate_upper  <= $signed(i_cfg_data[DATA_WIDTH-1:0]);
                CFG_RATE_LOWER:  r_rate_lower  <= $signed(i_cfg_data[DATA_WIDTH-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_sample    <= n_sample;
        r_arg       <= n_arg;
        r_pass      <= n_pass;
        r_top       <= n_top;
        r_sum       <= n_sum;
        r_new_value <= n_new_value;
        r_new_rate  <= n_new_rate;
        r_new_turns <= n_new_turns;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.value_out = r_value;
    assign o_out.rate_out  = r_rate;
    assign o_out.turns_out = r_turns;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second word accepted while a command is in flight");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_stat.busy || w_stat.done))
        else $error("waiting on a division that is not running");

    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_turns != $past(r_turns))) |->
            ((r_turns - $past(r_turns)) == TURN_STEP) ||
            (($past(r_turns) - r_turns) == TURN_STEP))
        else $error("turn count moved by other than one wrap");

    a_commit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_value != $past(r_value))) |-> ($past(r_state) == S_OUT))
        else $error("channel value changed outside the commit step");

endmodule

// ===== tb/sv/command_slew_limiter_test.sv =====
// ----------------------------------------------------------------------------
// command_slew_limiter_test: self-checking bench for the command slew limiter
// Walks a short table of directed commands and register writes, then runs
// random phases of commands under random settings. Each accepted command is
// run through a behavioral model of the shaper. Every returned word is
// compared field by field with the oldest awaited word. Both channels
// idle at random outside the two calm phases.
// ----------------------------------------------------------------------------
module command_slew_limiter_test;

    import csl_pkg::*;

    localparam int DATA_WIDTH     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int CFG_DATA_WIDTH = (DATA_WIDTH > DT_WIDTH) ? DATA_WIDTH : DT_WIDTH;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;

    // The slowest word is a division step; the tail and the
    // idle check give it room before anything is judged.
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 70;
    localparam int STUCK_LIMIT    = 2000;

    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 50;

    localparam logic OP_LIMITED    = 1'b0;
    localparam logic OP_WRAP       = 1'b1;
    localparam logic MODE_POSITION = 1'b0;
    localparam logic MODE_VELOCITY = 1'b1;

    // Kinds of directed row and how a row's result is checked
    localparam logic ITEM    = 1'b0;
    localparam logic SETUP   = 1'b1;
    localparam logic CHECKED = 1'b0;
    localparam logic TYPED   = 1'b1;

    localparam longint Q_MAX        = 64'sh7FFF_FFFF;
    localparam longint Q_MIN        = -64'sh8000_0000;
    localparam longint ONE_Q        = 64'sd1 <<< FRAC_BITS;
    // pi and 2*pi rounded to nearest at 16 fraction bits
    localparam longint ANGLE_PI     = 64'sd205887;
    localparam longint ANGLE_TWO_PI = 64'sd411775;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic signed [DATA_WIDTH-1:0] rate;
        logic signed [TURN_WIDTH-1:0] turns;
    } shaped_t;

    localparam shaped_t NO_WORD = '0;

    typedef struct packed {
        logic           setup;
        t_cfg_idx       idx;
        logic           op;
        logic [31:0]    word;
        logic           typed;
        shaped_t        want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 39;

    // Directed stimulus. Typed rows carry their result: they start from reset,
    // where the bounds are wide open and dt is 655 (step 21463039 per max rate).
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // reset settings: zero command, full-scale targets, first angles
        '{ITEM,  CFG_MODE,        OP_WRAP,    32'h0000_0000, TYPED,
          '{32'h0000_0000, 32'h0000_0000, 16'h0000}},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0000_0000, TYPED,
          '{32'h0000_0000, 32'h0000_0000, 16'h0000}},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h7FFF_FFFF, TYPED,
          '{32'h0147_7FFF, 32'h7FFF_FFFF, 16'h0000}},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h8000_0000, TYPED,
          '{32'hFFFF_FFFF, 32'h8000_0000, 16'h0000}},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'hFFFF_FFFF, TYPED,
          '{32'hFFFF_FFFF, 32'h0000_0000, 16'h0000}},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0000_0064, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'hFFFF_EC78, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_WRAP,    32'h7FFF_FFFF, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_WRAP,    32'h8000_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_WRAP,    32'h0001_0000, CHECKED, NO_WORD},
        // dt of one second, value within +-5.0, rate within +-2.0
        '{SETUP, CFG_STEP_TIME,   OP_LIMITED, 32'h0001_0000, CHECKED, NO_WORD},
        '{SETUP, CFG_VALUE_UPPER, OP_LIMITED, 32'h0005_0000, CHECKED, NO_WORD},
        '{SETUP, CFG_VALUE_LOWER, OP_LIMITED, 32'hFFFB_0000, CHECKED, NO_WORD},
        '{SETUP, CFG_RATE_UPPER,  OP_LIMITED, 32'h0002_0000, CHECKED, NO_WORD},
        '{SETUP, CFG_RATE_LOWER,  OP_LIMITED, 32'hFFFE_0000, CHECKED, NO_WORD},
        // target above, below, then rate limited, then a divided step
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0006_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'hFFF0_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0000_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'hFFFD_8000, CHECKED, NO_WORD},
        // velocity: clamp both ways, then integrate into the upper value bound
        '{SETUP, CFG_MODE,        OP_LIMITED, 32'h0000_0001, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h7FFF_FFFF, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h8000_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0002_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0002_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0002_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0002_0000, CHECKED, NO_WORD},
        // crossed value bounds: the upper test wins where both apply
        '{SETUP, CFG_MODE,        OP_LIMITED, 32'h0000_0000, CHECKED, NO_WORD},
        '{SETUP, CFG_VALUE_UPPER, OP_LIMITED, 32'hFFFF_0000, CHECKED, NO_WORD},
        '{SETUP, CFG_VALUE_LOWER, OP_LIMITED, 32'h0001_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0000_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h8000_0000, CHECKED, NO_WORD},
        // smallest dt with everything wide open again
        '{SETUP, CFG_STEP_TIME,   OP_LIMITED, 32'h0000_0001, CHECKED, NO_WORD},
        '{SETUP, CFG_VALUE_UPPER, OP_LIMITED, 32'h7FFF_FFFF, CHECKED, NO_WORD},
        '{SETUP, CFG_VALUE_LOWER, OP_LIMITED, 32'h8000_0000, CHECKED, NO_WORD},
        '{SETUP, CFG_RATE_UPPER,  OP_LIMITED, 32'h7FFF_FFFF, CHECKED, NO_WORD},
        '{SETUP, CFG_RATE_LOWER,  OP_LIMITED, 32'h8000_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h7FFF_FFFF, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_LIMITED, 32'h0001_0000, CHECKED, NO_WORD},
        '{ITEM,  CFG_MODE,        OP_WRAP,    32'h7FFF_FFFF, CHECKED, NO_WORD}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    csl_in_if  #(.DATA_WIDTH(DATA_WIDTH)) cmd_if ();
    csl_out_if #(.DATA_WIDTH(DATA_WIDTH)) shaped_if ();

    command_slew_limiter #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (cmd_if),
        .o_out      (shaped_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shaper state and register shadow, advanced on every accepted word
    longint            cur_value;
    longint            cur_rate;
    logic [15:0]       cur_turns;
    logic              cfg_mode;
    longint            cfg_dt;
    longint            cfg_vu;
    longint            cfg_vl;
    longint            cfg_ru;
    longint            cfg_rl;

    shaped_t           awaited_words [$];
    int                mismatches;
    int                stuck_cycles;
    logic              calm;          // no idling on either channel while set
    int                stall_left;

    function automatic longint saturate_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // rate * dt, floored at the fraction point
    function automatic longint times_step(input longint r);
        return (r * cfg_dt) >>> FRAC_BITS;
    endfunction

    function automatic shaped_t shape_command(input logic op, input logic [31:0] word);
        longint  s;
        longint  top;
        longint  bot;
        longint  r;
        longint  q;
        shaped_t res;
        s = $signed(word);
        if (op == OP_WRAP) begin
            // integrate the angle, fold back by one turn at most
            cur_rate  = s;
            cur_value = saturate_q(cur_value + times_step(s));
            if (cur_value > ANGLE_PI) begin
                cur_value = saturate_q(cur_value - ANGLE_TWO_PI);
                cur_turns = cur_turns + TURN_STEP;
            end else if (cur_value < -ANGLE_PI) begin
                cur_value = saturate_q(cur_value + ANGLE_TWO_PI);
                cur_turns = cur_turns - TURN_STEP;
            end
        end else if (cfg_mode == MODE_POSITION) begin
            if (s > cfg_vu) begin
                cur_value = cfg_vu;
                cur_rate  = 0;
            end else if (s < cfg_vl) begin
                cur_value = cfg_vl;
                cur_rate  = 0;
            end else begin
                top = saturate_q(cur_value + times_step(cfg_ru));
                bot = saturate_q(cur_value + times_step(cfg_rl));
                if (s > top) begin
                    cur_rate  = cfg_ru;
                    cur_value = top;
                end else if (s < bot) begin
                    cur_rate  = cfg_rl;
                    cur_value = bot;
                end else begin
                    // exact difference over dt, truncated toward zero
                    q = 0;
                    if (cfg_dt != 0) begin
                        q = ((s - cur_value) * ONE_Q) / cfg_dt;
                    end
                    cur_rate  = saturate_q(q);
                    cur_value = s;
                end
            end
        end else begin
            r = s;
            if (r > cfg_ru) begin
                r = cfg_ru;
            end else if (r < cfg_rl) begin
                r = cfg_rl;
            end
            cur_value = saturate_q(cur_value + times_step(r));
            if (cur_value > cfg_vu) begin
                cur_value = cfg_vu;
                cur_rate  = 0;
            end else if (cur_value < cfg_vl) begin
                cur_value = cfg_vl;
                cur_rate  = 0;
            end else begin
                cur_rate = r;
            end
        end
        res.value = cur_value[31:0];
        res.rate  = cur_rate[31:0];
        res.turns = cur_turns;
        return res;
    endfunction

    // Bound level: an extreme, anything, or a modest value within +-10.0
    function automatic logic [31:0] random_level();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;
        endcase
    endfunction

    // Pick an upper/lower pair: mostly ordered, sometimes open or crossed
    function automatic void pick_bounds(output logic [31:0] hi, output logic [31:0] lo);
        logic [31:0] a;
        logic [31:0] b;
        a = random_level();
        b = random_level();
        case ($urandom_range(9))
            0: begin
                hi = 32'h7FFF_FFFF;
                lo = 32'h8000_0000;
            end
            1: begin
                hi = b;
                lo = a;
            end
            default: begin
                if ($signed(a) >= $signed(b)) begin
                    hi = a;
                    lo = b;
                end else begin
                    hi = b;
                    lo = a;
                end
            end
        endcase
    endfunction

    // Write one register and mirror it; leave the enable high for the caller
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:        cfg_mode = data[0];
            CFG_STEP_TIME:   cfg_dt   = longint'(data[DT_WIDTH-1:0]);
            CFG_VALUE_UPPER: cfg_vu   = $signed(data);
            CFG_VALUE_LOWER: cfg_vl   = $signed(data);
            CFG_RATE_UPPER:  cfg_ru   = $signed(data);
            CFG_RATE_LOWER:  cfg_rl   = $signed(data);
            default: ;
        endcase
    endtask

    // Offer one command word; predict its result once it is taken
    task automatic send_command(input logic op, input logic [31:0] word,
                                input logic typed, input shaped_t typed_word);
        shaped_t predicted;
        if (!calm && $urandom_range(99) < 35) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.op     <= op;
        cmd_if.sample <= word;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        predicted = shape_command(op, word);
        awaited_words.push_back(typed ? typed_word : predicted);
    endtask

    // Drop valid, then hold until every predicted word has come back
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: check each taken word, then pick the next ready level
    initial begin
        shaped_t want;
        shaped_if.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && shaped_if.valid === 1'b1 && shaped_if.ready === 1'b1) begin
                if (awaited_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word value %h rate %h turns %h", $time,
                             shaped_if.value_out, shaped_if.rate_out, shaped_if.turns_out);
                end else begin
                    want = awaited_words.pop_front();
                    if (shaped_if.value_out !== want.value) begin
                        mismatches++;
                        $display("%0t: value_out expected %h actual %h", $time,
                                 want.value, shaped_if.value_out);
                    end
                    if (shaped_if.rate_out !== want.rate) begin
                        mismatches++;
                        $display("%0t: rate_out expected %h actual %h", $time,
                                 want.rate, shaped_if.rate_out);
                    end
                    if (shaped_if.turns_out !== want.turns) begin
                        mismatches++;
                        $display("%0t: turns_out expected %h actual %h", $time,
                                 want.turns, shaped_if.turns_out);
                    end
                end
            end
            // Mostly single-cycle stalls; now and then a long one so that a
            // finished word sits while the next command is taken.
            if (calm) begin
                shaped_if.ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                shaped_if.ready <= 1'b0;
            end else if ($urandom_range(99) < 35) begin
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(90) : 0;
                shaped_if.ready <= 1'b0;
            end else begin
                shaped_if.ready <= 1'b1;
            end
        end
    end

    // End the run if nothing moves for too long
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (shaped_if.valid && shaped_if.ready) ||
                cfg_we || !i_rst_n) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus: reset, directed table, random phases, drain
    initial begin
        int          phase;
        int          n;
        logic        writing;
        logic        op;
        logic [31:0] word;
        logic [31:0] mode_word;
        logic [31:0] dt_word;
        logic [31:0] vu;
        logic [31:0] vl;
        logic [31:0] ru;
        logic [31:0] rl;
        logic [16:0] dt;
        longint      span;
        longint      base;

        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_MODE;
        cfg_data      <= '0;
        cmd_if.valid  <= 1'b0;
        cmd_if.op     <= OP_LIMITED;
        cmd_if.sample <= '0;

        mismatches = 0;
        calm       = 1'b0;
        writing    = 1'b0;
        cur_value  = 0;
        cur_rate   = 0;
        cur_turns  = '0;
        cfg_mode   = MODE_POSITION;
        cfg_dt     = longint'(DT_RESET);
        cfg_vu     = Q_MAX;
        cfg_vl     = Q_MIN;
        cfg_ru     = Q_MAX;
        cfg_rl     = Q_MIN;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table; drain before the first write of each group and
        // drop the enable again before the next command.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].setup == SETUP) begin
                if (!writing) begin
                    wait_idle();
                    writing = 1'b1;
                end
                write_reg(directed_rows[k].idx, directed_rows[k].word);
            end else begin
                if (writing) begin
                    cfg_we  <= 1'b0;
                    writing = 1'b0;
                end
                send_command(directed_rows[k].op, directed_rows[k].word,
                             directed_rows[k].typed, directed_rows[k].want);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            // two phases run with both channels streaming flat out
            calm = (phase == 4 || phase == 5);

            // Settings: dt extremes first, both modes early, then anything.
            // Unused upper bits of the mode and dt words carry noise.
            mode_word = $urandom;
            if (phase < 4) begin
                mode_word[0] = phase[0];
            end
            case (phase)
                0: dt = 17'h1_0000;
                1: dt = 17'd1;
                default: begin
                    case ($urandom_range(4))
                        0:       dt = 17'd1;
                        1:       dt = 17'h1_0000;
                        2:       dt = DT_RESET;
                        3:       dt = $urandom_range(1, 17'h1_0000);
                        default: dt = $urandom_range(1, 64);
                    endcase
                end
            endcase
            dt_word = $urandom;
            dt_word[DT_WIDTH-1:0] = dt;
            if (phase == 0) begin
                vu = 32'h7FFF_FFFF;
                vl = 32'h8000_0000;
                ru = 32'h7FFF_FFFF;
                rl = 32'h8000_0000;
            end else begin
                pick_bounds(vu, vl);
                pick_bounds(ru, rl);
            end
            write_reg(CFG_MODE, mode_word);
            write_reg(CFG_STEP_TIME, dt_word);
            write_reg(CFG_VALUE_UPPER, vu);
            write_reg(CFG_VALUE_LOWER, vl);
            write_reg(CFG_RATE_UPPER, ru);
            write_reg(CFG_RATE_LOWER, rl);
            cfg_we <= 1'b0;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                op = ($urandom_range(3) == 0) ? OP_WRAP : OP_LIMITED;
                case ($urandom_range(9))
                    0: begin
                        case ($urandom_range(4))
                            0:       word = 32'h0000_0000;
                            1:       word = 32'h7FFF_FFFF;
                            2:       word = 32'h8000_0000;
                            3:       word = 32'h0000_0001;
                            default: word = 32'hFFFF_FFFF;
                        endcase
                    end
                    1, 2: word = $urandom;
                    3, 4, 5: begin
                        // near the present value, to reach the divided step
                        span = 64'sd1 <<< $urandom_range(0, 18);
                        base = saturate_q(cur_value - span +
                                          longint'($urandom_range(0, 2 * span)));
                        word = base[31:0];
                    end
                    6, 7: begin
                        if (cfg_vu >= cfg_vl) begin
                            span = cfg_vu - cfg_vl + 1;
                            base = cfg_vl + (longint'({$urandom, $urandom} >> 1) % span);
                            word = base[31:0];
                        end else begin
                            word = $urandom;
                        end
                    end
                    default: word = $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;
                endcase
                send_command(op, word, CHECKED, NO_WORD);
            end
        end

        calm = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
